@@ rtl/smf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_pkg
// Shared constants, types and sorting helpers for the sliding window
// median filter.
// ----------------------------------------------------------------------------
package smf_pkg;

   // Kernel size and the widest row the line store holds.
   localparam int KERNEL    = 3;
   localparam int MAX_WIDTH = 2048;

   // Window geometry. DLY is the number of rows and columns a pixel waits
   // before its whole window has arrived.
   localparam int HALF  = KERNEL / 2;
   localparam int DLY   = KERNEL - 1 - HALF;
   localparam int WIN_N = KERNEL * KERNEL;

   // Field and counter widths.
   localparam int WIDTH_W  = 12;
   localparam int HEIGHT_W = 13;
   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int WEFF_W   = COL_W + 1;
   localparam int ROW_W    = HEIGHT_W;
   localparam int BANK_W   = $clog2(KERNEL);
   localparam int PEND_W   = $clog2(DLY * MAX_WIDTH + DLY + 2);

   // Sorting pipeline: odd-even transposition rounds per register stage.
   localparam int ROUNDS_PER_STAGE = 3;
   localparam int SORT_STAGES      = (WIN_N + ROUNDS_PER_STAGE - 1) / ROUNDS_PER_STAGE;

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = HEIGHT_W;
   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } op_type;

   // One window of pixels; element order does not matter to the median.
   typedef logic [WIN_N-1:0][7:0] win_type;

   // Per-item control that travels alongside the window.
   typedef struct packed {
      logic [7:0] center;
      logic       interior;
      logic       last;
   } pix_info_type;

   // A few rounds of an odd-even transposition sort, starting at round
   // number first. After WIN_N rounds in total the window is sorted.
   function automatic win_type sort_rounds(win_type win, int first);
      win_type    a;
      logic [7:0] t;
      a = win;
      for (int r = 0; r < ROUNDS_PER_STAGE; r++) begin
         if (first + r < WIN_N) begin
            for (int i = 0; i < WIN_N - 1; i++) begin
               if ((i % 2) == ((first + r) % 2)) begin
                  if (a[i] > a[i+1]) begin
                     t      = a[i];
                     a[i]   = a[i+1];
                     a[i+1] = t;
                  end
               end
            end
         end
      end
      return a;
   endfunction

   // Median of a sorted window; the floor average of the middle pair when
   // the window size is even.
   function automatic logic [7:0] pick_median(win_type sorted);
      logic [8:0] sum;
      sum = {1'b0, sorted[WIN_N/2 - ((WIN_N + 1) % 2)]} + {1'b0, sorted[WIN_N/2]};
      if ((WIN_N % 2) != 0) begin
         return sorted[WIN_N/2];
      end
      return sum[8:1];
   endfunction

endpackage

@@ rtl/smf_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_stream_if
// Valid/ready stream channels for pixel items going in and results coming
// out of the median filter.
// ----------------------------------------------------------------------------

// Input channel: raster pixels and drain ticks.
interface smf_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] pixel_in;

   modport source (output valid, output op, output pixel_in, input ready);
   modport sink   (input valid, input op, input pixel_in, output ready);
endinterface

// Result channel: filtered pixels with an end-of-frame mark.
interface smf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_out;
   logic       frame_end;

   modport source (output valid, output pixel_out, output frame_end, input ready);
   modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

@@ rtl/smf_line_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_line_store
// Ring of KERNEL row banks. Each bank takes one write and two registered
// reads per cycle: one read for the window column, one for the center pixel.
// ----------------------------------------------------------------------------
module smf_line_store (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [smf_pkg::BANK_W-1:0]           wr_bank,
   input  logic [smf_pkg::COL_W-1:0]            wr_addr,
   input  logic [7:0]                           wr_data,
   input  logic                                 rd_en,
   input  logic [smf_pkg::COL_W-1:0]            rd_addr_a,
   input  logic [smf_pkg::COL_W-1:0]            rd_addr_b,
   output logic [smf_pkg::KERNEL-1:0][7:0]      rd_data_a,
   output logic [smf_pkg::KERNEL-1:0][7:0]      rd_data_b
);

   for (genvar b = 0; b < smf_pkg::KERNEL; b++) begin : g_bank
      logic [7:0] bank_mem [smf_pkg::MAX_WIDTH];

      // Write the incoming pixel into the bank of its row.
      always_ff @(posedge clock) begin
         if (wr_en && (wr_bank == smf_pkg::BANK_W'(b))) begin
            bank_mem[wr_addr] <= wr_data;
         end
      end

      // Both reads are registered and only move when an item is taken.
      always_ff @(posedge clock) begin
         if (rd_en) begin
            rd_data_a[b] <= bank_mem[rd_addr_a];
            rd_data_b[b] <= bank_mem[rd_addr_b];
         end
      end
   end

endmodule

@@ rtl/smf_median_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_median_pipe
// Pipelined odd-even transposition sorter. Each stage runs a few rounds of
// compare-exchange and holds its item until the next stage can take it.
// ----------------------------------------------------------------------------
module smf_median_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  smf_pkg::win_type      in_win,
   input  smf_pkg::pix_info_type in_info,
   output logic                  out_valid,
   input  logic                  out_ready,
   output smf_pkg::win_type      out_win,
   output smf_pkg::pix_info_type out_info
);

   logic [smf_pkg::SORT_STAGES-1:0] st_valid_ff;
   logic [smf_pkg::SORT_STAGES-1:0] st_ready;
   smf_pkg::win_type                st_win_ff  [smf_pkg::SORT_STAGES];
   smf_pkg::pix_info_type           st_info_ff [smf_pkg::SORT_STAGES];

   for (genvar j = 0; j < smf_pkg::SORT_STAGES; j++) begin : g_stage
      logic                  src_valid;
      smf_pkg::win_type      src_win;
      smf_pkg::pix_info_type src_info;
      logic                  next_ready;

      // Hook the stage to its upstream and downstream neighbors.
      if (j == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_win   = in_win;
         assign src_info  = in_info;
      end else begin : g_chain
         assign src_valid = st_valid_ff[j-1];
         assign src_win   = st_win_ff[j-1];
         assign src_info  = st_info_ff[j-1];
      end

      if (j == smf_pkg::SORT_STAGES - 1) begin : g_tail
         assign next_ready = out_ready;
      end else begin : g_body
         assign next_ready = st_ready[j+1];
      end

      // A stage can load when it is empty or its item moves on.
      assign st_ready[j] = !st_valid_ff[j] || next_ready;

      always_ff @(posedge clock) begin
         if (reset) begin
            st_valid_ff[j] <= 1'b0;
         end else if (st_ready[j]) begin
            st_valid_ff[j] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (st_ready[j] && src_valid) begin
            st_win_ff[j]  <= smf_pkg::sort_rounds(src_win, j * smf_pkg::ROUNDS_PER_STAGE);
            st_info_ff[j] <= src_info;
         end
      end
   end

   assign in_ready  = st_ready[0];
   assign out_valid = st_valid_ff[smf_pkg::SORT_STAGES-1];
   assign out_win   = st_win_ff[smf_pkg::SORT_STAGES-1];
   assign out_info  = st_info_ff[smf_pkg::SORT_STAGES-1];

endmodule

@@ rtl/sliding_window_median_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_filter
// Streaming KERNEL x KERNEL median filter for 8-bit raster frames.
// Throughput: one item per cycle while the result side takes results, set by
// the single write and registered reads of each line store bank and a fully
// pipelined sorter. A result passes the read stage, SORT_STAGES sorter stages
// and result register after the item that releases it; pixel (r,c) is
// released DLY*(width+1) pixels later; drain items release a frame's tail.
// Reset: counters clear, width and height return to 640 and 480; the line
// store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_median_filter (
   input  logic                               clock,
   input  logic                               reset,
   smf_req_if.sink                            req_stream,
   smf_rsp_if.source                          rsp_stream,
   input  logic                               csr_write_en,
   input  logic [smf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [smf_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   // Configuration registers and their effective values.
   logic [smf_pkg::WIDTH_W-1:0]  image_width_ff;
   logic [smf_pkg::HEIGHT_W-1:0] image_height_ff;
   logic [smf_pkg::WEFF_W-1:0]   w_eff;
   logic [smf_pkg::HEIGHT_W-1:0] h_eff;

   // Frame position counters.
   logic [smf_pkg::COL_W-1:0]  in_col_ff, in_col_in;
   logic [smf_pkg::ROW_W-1:0]  in_row_ff, in_row_in;
   logic [smf_pkg::BANK_W-1:0] in_bank_ff, in_bank_in;
   logic [smf_pkg::COL_W-1:0]  out_col_ff, out_col_in;
   logic [smf_pkg::ROW_W-1:0]  out_row_ff, out_row_in;
   logic [smf_pkg::BANK_W-1:0] out_bank_ff, out_bank_in;
   logic [smf_pkg::PEND_W-1:0] pending_ff, pending_in;

   // Front-end decisions for the item being taken.
   logic accept;
   logic is_pix;
   logic in_done;
   logic emit;
   logic interior;
   logic last;
   logic fwd;

   // Stage after the line store read.
   logic                       s1_valid_ff;
   logic                       s1_pix_ff;
   logic                       s1_emit_ff;
   logic [7:0]                 s1_pixel_ff;
   logic [smf_pkg::BANK_W-1:0] s1_bank_ff;
   logic [smf_pkg::BANK_W-1:0] s1_obank_ff;
   logic                       s1_fwd_ff;
   logic                       s1_interior_ff;
   logic                       s1_last_ff;
   logic                       s1_advance;

   logic [smf_pkg::KERNEL-1:0][7:0] rd_data_a;
   logic [smf_pkg::KERNEL-1:0][7:0] rd_data_b;
   smf_pkg::win_type                window_ff;
   smf_pkg::win_type                win_next;
   smf_pkg::pix_info_type           s1_info;

   // Sorter and result register.
   logic                  mp_in_ready;
   logic                  mp_out_valid;
   logic                  mp_out_ready;
   smf_pkg::win_type      mp_out_win;
   smf_pkg::pix_info_type mp_out_info;
   logic                  rsp_valid_ff;
   logic [7:0]            rsp_pixel_ff;
   logic                  rsp_frame_end_ff;

   // A zero width or height acts as one; a width beyond the store is clamped.
   always_comb begin
      if (image_width_ff == '0) begin
         w_eff = smf_pkg::WEFF_W'(1);
      end else if (32'(image_width_ff) > 32'(smf_pkg::MAX_WIDTH)) begin
         w_eff = smf_pkg::WEFF_W'(smf_pkg::MAX_WIDTH);
      end else begin
         w_eff = smf_pkg::WEFF_W'(image_width_ff);
      end
      h_eff = (image_height_ff == '0) ? smf_pkg::HEIGHT_W'(1) : image_height_ff;
   end

   assign req_stream.ready = s1_advance;
   assign accept           = req_stream.valid && s1_advance;

   // Decide what the item does and step the raster counters.
   always_comb begin
      in_done  = (in_row_ff >= h_eff);
      is_pix   = (req_stream.op == smf_pkg::OP_PIXEL) && !in_done;
      interior = (32'(out_row_ff) >= 32'(smf_pkg::HALF))
              && (32'(out_col_ff) >= 32'(smf_pkg::HALF))
              && (32'(out_row_ff) + 32'(smf_pkg::HALF) < 32'(h_eff))
              && (32'(out_col_ff) + 32'(smf_pkg::HALF) < 32'(w_eff));
      last     = (32'(out_row_ff) + 32'd1 >= 32'(h_eff))
              && (32'(out_col_ff) + 32'd1 >= 32'(w_eff));
      fwd      = is_pix && (out_bank_ff == in_bank_ff) && (out_col_ff == in_col_ff);

      if (is_pix) begin
         emit = accept && (32'(pending_ff) >=
                (32'(smf_pkg::DLY) * 32'(w_eff) + 32'(smf_pkg::DLY)));
      end else begin
         emit = accept && in_done;
      end

      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_bank_in  = in_bank_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_bank_in = out_bank_ff;
      pending_in  = pending_ff;

      // A pixel goes into the store and advances the input position.
      if (accept && is_pix) begin
         pending_in = pending_ff + smf_pkg::PEND_W'(1);
         if (32'(in_col_ff) + 32'd1 >= 32'(w_eff)) begin
            in_col_in  = '0;
            in_row_in  = in_row_ff + smf_pkg::ROW_W'(1);
            in_bank_in = (in_bank_ff == smf_pkg::BANK_W'(smf_pkg::KERNEL - 1))
                       ? '0 : in_bank_ff + smf_pkg::BANK_W'(1);
         end else begin
            in_col_in = in_col_ff + smf_pkg::COL_W'(1);
         end
      end

      // A result advances the output position; the last one restarts the frame.
      if (emit) begin
         pending_in = pending_in - smf_pkg::PEND_W'(1);
         if (last) begin
            in_col_in   = '0;
            in_row_in   = '0;
            in_bank_in  = '0;
            out_col_in  = '0;
            out_row_in  = '0;
            out_bank_in = '0;
            pending_in  = '0;
         end else if (32'(out_col_ff) + 32'd1 >= 32'(w_eff)) begin
            out_col_in  = '0;
            out_row_in  = out_row_ff + smf_pkg::ROW_W'(1);
            out_bank_in = (out_bank_ff == smf_pkg::BANK_W'(smf_pkg::KERNEL - 1))
                        ? '0 : out_bank_ff + smf_pkg::BANK_W'(1);
         end else begin
            out_col_in = out_col_ff + smf_pkg::COL_W'(1);
         end
      end
   end

   // Configuration writes and counter state; a write restarts the frame.
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= smf_pkg::WIDTH_W'(smf_pkg::WIDTH_RESET);
         image_height_ff <= smf_pkg::HEIGHT_W'(smf_pkg::HEIGHT_RESET);
         in_col_ff       <= '0;
         in_row_ff       <= '0;
         in_bank_ff      <= '0;
         out_col_ff      <= '0;
         out_row_ff      <= '0;
         out_bank_ff     <= '0;
         pending_ff      <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            smf_pkg::REG_IMAGE_WIDTH: begin
               image_width_ff <= csr_write_data[smf_pkg::WIDTH_W-1:0];
            end
            smf_pkg::REG_IMAGE_HEIGHT: begin
               image_height_ff <= csr_write_data[smf_pkg::HEIGHT_W-1:0];
            end
         endcase
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_bank_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_bank_ff <= '0;
         pending_ff  <= '0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_bank_ff  <= in_bank_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_bank_ff <= out_bank_in;
         pending_ff  <= pending_in;
      end
   end

   smf_line_store u_line_store (
      .clock     (clock),
      .wr_en     (accept && is_pix),
      .wr_bank   (in_bank_ff),
      .wr_addr   (in_col_ff),
      .wr_data   (req_stream.pixel_in),
      .rd_en     (accept),
      .rd_addr_a (in_col_ff),
      .rd_addr_b (out_col_ff),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // Read stage control: an item that yields no result leaves at once.
   assign s1_advance = !s1_valid_ff || !s1_emit_ff || mp_in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         s1_valid_ff <= req_stream.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff      <= is_pix;
         s1_emit_ff     <= emit;
         s1_pixel_ff    <= req_stream.pixel_in;
         s1_bank_ff     <= in_bank_ff;
         s1_obank_ff    <= out_bank_ff;
         s1_fwd_ff      <= fwd;
         s1_interior_ff <= interior && is_pix;
         s1_last_ff     <= last;
      end
   end

   // Shift the new column into the window. The bank of the current row
   // holds stale data, so the incoming pixel takes its place.
   always_comb begin
      for (int b = 0; b < smf_pkg::KERNEL; b++) begin
         win_next[b] = (smf_pkg::BANK_W'(b) == s1_bank_ff) ? s1_pixel_ff : rd_data_a[b];
      end
      for (int i = smf_pkg::KERNEL; i < smf_pkg::WIN_N; i++) begin
         win_next[i] = window_ff[i - smf_pkg::KERNEL];
      end
      s1_info.center   = s1_fwd_ff ? s1_pixel_ff : rd_data_b[s1_obank_ff];
      s1_info.interior = s1_interior_ff;
      s1_info.last     = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (s1_valid_ff && s1_advance && s1_pix_ff) begin
         window_ff <= win_next;
      end
   end

   smf_median_pipe u_median_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff && s1_emit_ff),
      .in_ready  (mp_in_ready),
      .in_win    (win_next),
      .in_info   (s1_info),
      .out_valid (mp_out_valid),
      .out_ready (mp_out_ready),
      .out_win   (mp_out_win),
      .out_info  (mp_out_info)
   );

   // Result register: median for interior pixels, center value elsewhere.
   assign mp_out_ready = !rsp_valid_ff || rsp_stream.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (mp_out_ready) begin
         rsp_valid_ff <= mp_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (mp_out_ready && mp_out_valid) begin
         rsp_pixel_ff     <= mp_out_info.interior ? smf_pkg::pick_median(mp_out_win)
                                                  : mp_out_info.center;
         rsp_frame_end_ff <= mp_out_info.last;
      end
   end

   assign rsp_stream.valid     = rsp_valid_ff;
   assign rsp_stream.pixel_out = rsp_pixel_ff;
   assign rsp_stream.frame_end = rsp_frame_end_ff;

endmodule

@@ bench/sliding_window_median_filter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_filter_tb
// Streams grayscale frames through the median filter and checks every
// filtered pixel against a line-store and window model kept in the bench.
// Frame sizes range from one pixel up to rows of 640 pixels, and up to
// frames thousands of rows tall.
// Both handshakes stall at random, and the checker compares each result
// with the oldest pixel still due.
// ----------------------------------------------------------------------------
module sliding_window_median_filter_tb;

   // Cycles to let the sorter pipeline empty before the block counts as idle.
   localparam int SETTLE_CYCLES = 3 + smf_pkg::SORT_STAGES + 8;
   localparam int RING_W        = $clog2(smf_pkg::KERNEL * smf_pkg::MAX_WIDTH);

   typedef struct packed {
      logic [7:0] pixel;
      logic       frame_end;
   } px_result_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_write_en;
   smf_pkg::reg_index_type         csr_index;
   logic [smf_pkg::CSR_DATA_W-1:0] csr_write_data;

   smf_req_if req_bus ();
   smf_rsp_if rsp_bus ();

   sliding_window_median_filter dut (
      .clock          (clock),
      .reset          (reset),
      .req_stream     (req_bus),
      .rsp_stream     (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // Bench copy of the frame geometry and filter state.
   logic [smf_pkg::WIDTH_W-1:0]  cfg_width;
   logic [smf_pkg::HEIGHT_W-1:0] cfg_height;
   logic [7:0]                   ring [smf_pkg::KERNEL*smf_pkg::MAX_WIDTH];
   int unsigned                  pred_in_col, pred_in_row, pred_out_col, pred_out_row;

   px_result_type pixels_due [$];
   int unsigned   items_sent = 0;
   int unsigned   mismatches = 0;
   bit            steady     = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // Effective geometry: zero acts as one, and rows are capped at the store size.
   function automatic int unsigned geom_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > smf_pkg::MAX_WIDTH) return smf_pkg::MAX_WIDTH;
      return 32'(cfg_width);
   endfunction

   function automatic int unsigned geom_height();
      return (cfg_height == 0) ? 1 : 32'(cfg_height);
   endfunction

   function automatic logic [7:0] ring_at(int unsigned row, int unsigned col);
      return ring[RING_W'((row % smf_pkg::KERNEL) * smf_pkg::MAX_WIDTH + col)];
   endfunction

   function automatic void rewind_frame();
      pred_in_col  = 0;
      pred_in_row  = 0;
      pred_out_col = 0;
      pred_out_row = 0;
   endfunction

   // Border pixels pass through; interior pixels take the window median.
   function automatic logic [7:0] window_median(int unsigned r, int unsigned c,
                                                int unsigned w, int unsigned h);
      logic [7:0] win [smf_pkg::WIN_N];
      logic [7:0] v;
      logic [8:0] sum;
      int         j;
      if (r < smf_pkg::HALF || c < smf_pkg::HALF ||
          r + smf_pkg::HALF >= h || c + smf_pkg::HALF >= w)
         return ring_at(r, c);
      for (int i = 0; i < smf_pkg::KERNEL; i++) begin
         for (int k = 0; k < smf_pkg::KERNEL; k++) begin
            win[i*smf_pkg::KERNEL + k] = ring_at(r - smf_pkg::HALF + i,
                                                 c - smf_pkg::HALF + k);
         end
      end
      // Insertion sort of the gathered window.
      for (int i = 1; i < smf_pkg::WIN_N; i++) begin
         v = win[i];
         j = i;
         while (j > 0 && win[j-1] > v) begin
            win[j] = win[j-1];
            j--;
         end
         win[j] = v;
      end
      if ((smf_pkg::WIN_N % 2) != 0) return win[smf_pkg::WIN_N/2];
      sum = {1'b0, win[smf_pkg::WIN_N/2 - 1]} + {1'b0, win[smf_pkg::WIN_N/2]};
      return sum[8:1];
   endfunction

   // Queue the next filtered pixel in raster order and advance the output position.
   function automatic void release_pixel(int unsigned w, int unsigned h);
      px_result_type res;
      logic          last;
      last          = (pred_out_row + 1 >= h) && (pred_out_col + 1 >= w);
      res.pixel     = window_median(pred_out_row, pred_out_col, w, h);
      res.frame_end = last;
      pixels_due.push_back(res);
      if (last) begin
         rewind_frame();
      end else begin
         pred_out_col++;
         if (pred_out_col >= w) begin
            pred_out_col = 0;
            pred_out_row++;
         end
      end
   endfunction

   // Apply one accepted item to the filter state.
   function automatic void advance_filter(smf_pkg::op_type op, logic [7:0] value);
      int unsigned w, h, lag, k_in, k_out;
      w   = geom_width();
      h   = geom_height();
      lag = smf_pkg::DLY * w + smf_pkg::DLY;
      // Drains, and pixels once the frame's input is complete, write nothing; they flush only then.
      if (op == smf_pkg::OP_DRAIN || pred_in_row >= h) begin
         if (pred_in_row >= h) release_pixel(w, h);
         return;
      end
      ring[RING_W'((pred_in_row % smf_pkg::KERNEL) * smf_pkg::MAX_WIDTH + pred_in_col)] =
         value;
      k_in = pred_in_row * w + pred_in_col;
      pred_in_col++;
      if (pred_in_col >= w) begin
         pred_in_col = 0;
         pred_in_row++;
      end
      k_out = pred_out_row * w + pred_out_col;
      if (k_out + lag <= k_in) release_pixel(w, h);
   endfunction

   // Scoreboard: check results, track register writes and accepted items.
   always @(posedge clock) begin : scoreboard
      px_result_type want;
      if (reset) begin
         cfg_width  = smf_pkg::WIDTH_W'(smf_pkg::WIDTH_RESET);
         cfg_height = smf_pkg::HEIGHT_W'(smf_pkg::HEIGHT_RESET);
         rewind_frame();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pixels_due.size() == 0) begin
               mismatches++;
               $error("unexpected result: pixel_out %0d frame_end %0d",
                      rsp_bus.pixel_out, rsp_bus.frame_end);
            end else begin
               want = pixels_due.pop_front();
               if (rsp_bus.pixel_out !== want.pixel) begin
                  mismatches++;
                  $error("pixel_out mismatch: expected %0d, actual %0d",
                         want.pixel, rsp_bus.pixel_out);
               end
               if (rsp_bus.frame_end !== want.frame_end) begin
                  mismatches++;
                  $error("frame_end mismatch: expected %0d, actual %0d",
                         want.frame_end, rsp_bus.frame_end);
               end
            end
         end
         if (csr_write_en) begin
            if (csr_index == smf_pkg::REG_IMAGE_WIDTH)
               cfg_width = csr_write_data[smf_pkg::WIDTH_W-1:0];
            else
               cfg_height = csr_write_data[smf_pkg::HEIGHT_W-1:0];
            rewind_frame();
         end
         if (req_bus.valid && req_bus.ready)
            advance_filter(smf_pkg::op_type'(req_bus.op), req_bus.pixel_in);
      end
   end

   // The result side stalls at random unless a steady stretch is running.
   always @(negedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99) >= 17);
   end

   function automatic logic [7:0] next_value(bit saturate);
      if (saturate) return $urandom_range(1) ? 8'hFF : 8'h00;
      return 8'($urandom_range(255));
   endfunction

   // Offer one item, with random gaps before it, and wait until it is taken.
   task automatic send_item(input smf_pkg::op_type op, input logic [7:0] value);
      while (!steady && $urandom_range(99) < 17) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.op       <= op;
      req_bus.pixel_in <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // Hold the input off until every due pixel has arrived and the pipe is empty.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pixels_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input smf_pkg::reg_index_type idx,
                            input logic [smf_pkg::CSR_DATA_W-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      @(negedge clock);
   endtask

   // Set a new frame size once the block is idle. The bit above the width
   // field is random, since the block must ignore it.
   task automatic configure(input int unsigned wv, input int unsigned hv);
      logic [smf_pkg::CSR_DATA_W-1:0] data;
      wait_drained();
      data                          = smf_pkg::CSR_DATA_W'(wv);
      data[smf_pkg::CSR_DATA_W-1]   = 1'($urandom_range(1));
      write_reg(smf_pkg::REG_IMAGE_WIDTH, data);
      write_reg(smf_pkg::REG_IMAGE_HEIGHT, smf_pkg::CSR_DATA_W'(hv));
   endtask

   // Send up to limit pixels of the current frame, with stray drain items
   // that arrive before the input is complete.
   task automatic stream_pixels(input int unsigned limit, input bit saturate);
      int unsigned n;
      n = 0;
      while (n < limit && pred_in_row < geom_height()) begin
         if ($urandom_range(99) < 4) begin
            send_item(smf_pkg::OP_DRAIN, next_value(1'b0));
         end else begin
            send_item(smf_pkg::OP_PIXEL, next_value(saturate));
            n++;
         end
      end
   endtask

   // Flush the tail of a complete frame with drains and late pixels.
   task automatic finish_frame();
      while (pred_in_row >= geom_height())
         send_item(smf_pkg::op_type'($urandom_range(1) ? smf_pkg::OP_DRAIN
                                                       : smf_pkg::OP_PIXEL),
                   next_value(1'b0));
   endtask

   // The reset geometry of 640 by 480, without any register write.
   task automatic test_reset_geometry();
      stream_pixels(660, 1'b0);
   endtask

   // Saturated values, an interior median, stray and late items, a 1x1 frame.
   task automatic test_directed_cases();
      logic [7:0] patch [9];
      patch = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd128, 8'd255, 8'd7, 8'd0, 8'd255};
      configure(3, 3);
      for (int i = 0; i < 9; i++) begin
         send_item(smf_pkg::OP_PIXEL, patch[i]);
         if (i == 2) send_item(smf_pkg::OP_DRAIN, 8'hFF);
      end
      send_item(smf_pkg::OP_DRAIN, 8'h00);
      send_item(smf_pkg::OP_PIXEL, 8'hFF);
      finish_frame();
      // Zero width and height act as a single pixel frame.
      configure(0, 0);
      send_item(smf_pkg::OP_PIXEL, 8'h00);
      send_item(smf_pkg::OP_DRAIN, 8'h00);
      send_item(smf_pkg::OP_DRAIN, 8'hFF);
   endtask

   // Random frames, mostly complete, some cut short or paused mid-frame.
   task automatic test_random_frames();
      int unsigned stop_at, area;
      int          roll;
      bit          fresh, split, saturate;
      fresh   = 1'b1;
      split   = 1'b1;
      stop_at = items_sent + 300;
      while (items_sent < stop_at) begin
         if (fresh || $urandom_range(99) < 70) begin
            roll = $urandom_range(99);
            configure(roll < 6 ? 0 : roll < 12 ? $urandom_range(13, 40) : $urandom_range(1, 12),
                      $urandom_range(99) < 6 ? 0 : $urandom_range(1, 8));
         end
         area     = geom_width() * geom_height();
         saturate = ($urandom_range(9) == 0);
         roll     = $urandom_range(99);
         if (roll < 15 && area > 1) begin
            stream_pixels($urandom_range(1, area - 1), saturate);
            fresh = 1'b1;
         end else begin
            if (split || roll < 25) begin
               stream_pixels($urandom_range(area), saturate);
               wait_drained();
               split = 1'b0;
            end
            stream_pixels(area, saturate);
            finish_frame();
            fresh = 1'b0;
         end
      end
   endtask

   // Frames back to back with neither side idling.
   task automatic test_back_to_back();
      steady = 1'b1;
      configure(16, 4);
      stream_pixels(64, 1'b0);
      finish_frame();
      configure(7, 5);
      repeat (2) begin
         stream_pixels(35, 1'b0);
         finish_frame();
      end
      steady = 1'b0;
   endtask

   // The tallest frames that the height register allows.
   task automatic test_size_extremes();
      configure(1, 8191);
      stream_pixels(60, 1'b0);
      configure(2, 4096);
      stream_pixels(60, 1'b1);
   endtask

   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.op       = smf_pkg::OP_PIXEL;
      req_bus.pixel_in = 8'h00;
      csr_write_en     = 1'b0;
      csr_index        = smf_pkg::REG_IMAGE_WIDTH;
      csr_write_data   = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_geometry();
      test_directed_cases();
      test_random_frames();
      test_back_to_back();
      test_size_extremes();

      wait_drained();
      if (mismatches == 0 && pixels_due.size() == 0) begin
         $display("sliding_window_median_filter_tb passed");
      end else begin
         $display("sliding_window_median_filter_tb failed");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #(5_000_000);
      $display("sliding_window_median_filter_tb failed");
      $finish;
   end

endmodule
